FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the Q-learning engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define TQLE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tqle assertion failed");

// Checks that a condition never holds at a rising clock edge outside reset.
`define TQLE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tqle assertion failed");

`endif

FILE: rtl/tqle_pkg.sv
package tqle_pkg;

  // Default table dimensions.
  localparam int unsigned GRID_SIDE_DEF  = 8;
  localparam int unsigned DIRECTIONS_DEF = 9;
  localparam int unsigned ACTIONS_DEF    = 5;

  // Fixed point constants (Q16.16 values, Q1.16 rates).
  localparam int unsigned        RATE_W       = 17;
  localparam int unsigned        Q_ONE        = 65536;
  localparam logic signed [31:0] START_VALUE  = -32'sd65536;
  localparam logic [2:0]         START_ACTION = 3'd4;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [RATE_W-1:0]  LR_RESET       = 17'd6554;
  localparam logic [RATE_W-1:0]  DISC_RESET     = 17'd58982;
  localparam logic signed [31:0] R_FINISH_RESET = 32'sd65536;
  localparam logic signed [31:0] R_ADJ_RESET    = 32'sd0;
  localparam logic signed [31:0] R_FAIL_RESET   = 32'sd0;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE   = 3'd0,
    CFG_DISCOUNT        = 3'd1,
    CFG_REWARD_FINISH   = 3'd2,
    CFG_REWARD_ADJACENT = 3'd3,
    CFG_REWARD_FAIL     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RWD_FAIL     = 2'd0,
    RWD_ADJACENT = 2'd1,
    RWD_FINISH   = 2'd2
  } rwd_kind_e;

  typedef enum logic {
    FUNC_UPDATE = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_e;

  // One request as it enters the engine.
  typedef struct packed {
    logic       func;
    logic       agent;
    logic [2:0] cur_x;
    logic [2:0] cur_y;
    logic [3:0] cur_dir;
    logic [2:0] cur_blind;
    logic [2:0] action;
    logic [2:0] next_x;
    logic [2:0] next_y;
    logic [3:0] next_dir;
    logic [2:0] next_blind;
    logic [1:0] reward_kind;
  } tqle_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr;
    logic addr1;
    logic addr2;
    logic scan_rd;
    logic cur_rd;
    logic cap_q;
    logic mul_g;
    logic tgt;
    logic mul_t;
    logic fin;
    logic out_load;
  } tqle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic is_query;
    logic out_free;
  } tqle_sts_t;

endpackage

FILE: rtl/tabular_q_learning_engine.sv
// Two-agent tabular Q-learning engine. Each agent has its own table of
// GRID_SIDE^3 * DIRECTIONS * ACTIONS signed Q16.16 entries, indexed by
// relative x, relative y, partner direction, blind count and action. A query
// request (tuser func = 1) returns the greedy action of the current state and
// its value; an update request (func = 0) finds the greedy value of the
// after-state and writes Q = (1-a)Q + a(r + g*maxQ), rounded and saturated.
// After reset the engine clears both tables, one entry of each per cycle;
// tready stays low meanwhile. Requests are then handled one at a time. A
// request forms its table addresses in two steps and scans the actions of
// the current state (query) or the after-state (update). A query then drains
// the last read; an update reads and captures the current entry, runs the
// multiply chain and writes the new value back. The result then waits for a
// free output register, and the next request can be accepted once it is
// loaded. The single read port of each table sets the scan length of one
// action per cycle, and the update adds a three-stage multiply chain. A
// finished result waits in the output register while the next request is
// accepted.
module tabular_q_learning_engine
  import tqle_pkg::*;
#(
  parameter int unsigned GRID_SIDE  = GRID_SIDE_DEF,
  parameter int unsigned DIRECTIONS = DIRECTIONS_DEF,
  parameter int unsigned ACTIONS    = ACTIONS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // cur_x[2:0], cur_y[5:3], cur_dir[9:6], cur_blind[12:10], action[15:13],
  // next_x[18:16], next_y[21:19], next_dir[25:22], next_blind[28:26],
  // reward_kind[30:29], zero[31]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // func[0], agent[1]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // best_action[2:0], best_value[34:3], new_value[66:35], zero[71:67]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  tqle_item_t item;
  tqle_cmd_t  cmd;
  tqle_sts_t  sts;

  // Unpack the request fields.
  assign item.func        = s_axis_tuser_i[0];
  assign item.agent       = s_axis_tuser_i[1];
  assign item.cur_x       = s_axis_tdata_i[2:0];
  assign item.cur_y       = s_axis_tdata_i[5:3];
  assign item.cur_dir     = s_axis_tdata_i[9:6];
  assign item.cur_blind   = s_axis_tdata_i[12:10];
  assign item.action      = s_axis_tdata_i[15:13];
  assign item.next_x      = s_axis_tdata_i[18:16];
  assign item.next_y      = s_axis_tdata_i[21:19];
  assign item.next_dir    = s_axis_tdata_i[25:22];
  assign item.next_blind  = s_axis_tdata_i[28:26];
  assign item.reward_kind = s_axis_tdata_i[30:29];

  tqle_controller u_controller (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .sts_i           (sts),
    .s_axis_tready_o (s_axis_tready_o),
    .cmd_o           (cmd)
  );

  tqle_datapath #(
    .GRID_SIDE  (GRID_SIDE),
    .DIRECTIONS (DIRECTIONS),
    .ACTIONS    (ACTIONS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .item_i          (item),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .sts_o           (sts)
  );

endmodule

FILE: rtl/tqle_datapath.sv
module tqle_datapath
  import tqle_pkg::*;
#(
  parameter int unsigned GRID_SIDE  = GRID_SIDE_DEF,
  parameter int unsigned DIRECTIONS = DIRECTIONS_DEF,
  parameter int unsigned ACTIONS    = ACTIONS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tqle_cmd_t              cmd_i,
  input  tqle_item_t             item_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   m_axis_tready_i,
  output logic                   m_axis_tvalid_o,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output tqle_sts_t              sts_o
);

  localparam int unsigned Depth = GRID_SIDE * GRID_SIDE * DIRECTIONS * GRID_SIDE * ACTIONS;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned ActW  = $clog2(ACTIONS);
  localparam int unsigned StartIdx =
    (ACTIONS > int'(START_ACTION)) ? int'(START_ACTION) : ACTIONS - 1;

  localparam logic [IdxW-1:0] GIdx     = IdxW'(GRID_SIDE);
  localparam logic [IdxW-1:0] DIdx     = IdxW'(DIRECTIONS);
  localparam logic [IdxW-1:0] AIdx     = IdxW'(ACTIONS);
  localparam logic [IdxW-1:0] LastAddr = IdxW'(Depth - 1);
  localparam logic [ActW-1:0] LastAct  = ActW'(ACTIONS - 1);
  localparam logic [ActW-1:0] StartAct = ActW'(StartIdx);

  // An index at or above its dimension maps to the last entry.
  function automatic logic [IdxW-1:0] clamp_f(input logic [3:0] v, input logic [IdxW-1:0] n);
    logic [IdxW-1:0] w;
    w = IdxW'(v);
    clamp_f = (w >= n) ? n - 1'b1 : w;
  endfunction

  // Configuration registers.
  logic [RATE_W-1:0]  lr_q, disc_q;
  logic signed [31:0] r_finish_q, r_adj_q, r_fail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q       <= LR_RESET;
      disc_q     <= DISC_RESET;
      r_finish_q <= R_FINISH_RESET;
      r_adj_q    <= R_ADJ_RESET;
      r_fail_q   <= R_FAIL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEARNING_RATE:   lr_q       <= cfg_wdata_i[RATE_W-1:0];
        CFG_DISCOUNT:        disc_q     <= cfg_wdata_i[RATE_W-1:0];
        CFG_REWARD_FINISH:   r_finish_q <= $signed(cfg_wdata_i[31:0]);
        CFG_REWARD_ADJACENT: r_adj_q    <= $signed(cfg_wdata_i[31:0]);
        CFG_REWARD_FAIL:     r_fail_q   <= $signed(cfg_wdata_i[31:0]);
        default: ;
      endcase
    end
  end

  // Latched request.
  tqle_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // Table addresses, built in two steps.
  logic [IdxW-1:0] part_cur_d, part_next_d, part_cur_q, part_next_q;
  logic [IdxW-1:0] base_cur_d, base_next_d, base_cur_q, base_next_q;
  logic [IdxW-1:0] cur_addr_d, cur_addr_q;

  assign part_cur_d = (clamp_f({1'b0, item_q.cur_x}, GIdx) * GIdx
                       + clamp_f({1'b0, item_q.cur_y}, GIdx)) * DIdx
                      + clamp_f(item_q.cur_dir, DIdx);
  assign part_next_d = (clamp_f({1'b0, item_q.next_x}, GIdx) * GIdx
                        + clamp_f({1'b0, item_q.next_y}, GIdx)) * DIdx
                       + clamp_f(item_q.next_dir, DIdx);
  assign base_cur_d  = (part_cur_q * GIdx + clamp_f({1'b0, item_q.cur_blind}, GIdx)) * AIdx;
  assign base_next_d = (part_next_q * GIdx + clamp_f({1'b0, item_q.next_blind}, GIdx)) * AIdx;
  assign cur_addr_d  = base_cur_d + clamp_f({1'b0, item_q.action}, AIdx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr1) begin
      part_cur_q  <= part_cur_d;
      part_next_q <= part_next_d;
    end
    if (cmd_i.addr2) begin
      base_cur_q  <= base_cur_d;
      base_next_q <= base_next_d;
      cur_addr_q  <= cur_addr_d;
    end
  end

  // Clearing pass counter.
  logic [IdxW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Scan counters: one read issued per cycle, compared in the cycle after it.
  logic [ActW-1:0] scan_idx_q, cmp_idx_q;
  logic            pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      cmp_idx_q  <= '0;
      pend_q     <= 1'b0;
    end else begin
      pend_q <= cmd_i.scan_rd;
      if (cmd_i.addr2) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        cmp_idx_q  <= scan_idx_q;
      end
    end
  end

  // Table memories, one per agent, with registered read data.
  logic [31:0]        mem_first_q  [Depth];
  logic [31:0]        mem_second_q [Depth];
  logic [31:0]        rd_first_q, rd_second_q;
  logic [IdxW-1:0]    scan_base, raddr, waddr;
  logic               rd_en, we_first, we_second;
  logic [31:0]        wdata;
  logic signed [31:0] rdata;
  logic signed [31:0] sat_d;

  assign scan_base = (item_q.func == FUNC_QUERY) ? base_cur_q : base_next_q;
  assign raddr     = cmd_i.scan_rd ? scan_base + IdxW'(scan_idx_q) : cur_addr_q;
  assign rd_en     = cmd_i.scan_rd | cmd_i.cur_rd;
  assign waddr     = cmd_i.clr ? clr_cnt_q : cur_addr_q;
  assign wdata     = cmd_i.clr ? '0 : sat_d;
  assign we_first  = cmd_i.clr | (cmd_i.fin & ~item_q.agent);
  assign we_second = cmd_i.clr | (cmd_i.fin & item_q.agent);
  assign rdata     = $signed(item_q.agent ? rd_second_q : rd_first_q);

  always_ff @(posedge clk_i) begin
    if (we_first) begin
      mem_first_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_first_q <= mem_first_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_second) begin
      mem_second_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_second_q <= mem_second_q[raddr];
    end
  end

  // Greedy scan: strict greater-than against the start value.
  logic signed [31:0] best_q, start_val_q, val_sel;
  logic [2:0]         best_act_q;
  logic               found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr2) begin
      best_q     <= START_VALUE;
      best_act_q <= START_ACTION;
      found_q    <= 1'b0;
    end else if (pend_q) begin
      if (rdata > best_q) begin
        best_q     <= rdata;
        best_act_q <= 3'(cmp_idx_q);
        found_q    <= 1'b1;
      end
      if (cmp_idx_q == StartAct) begin
        start_val_q <= rdata;
      end
    end
  end

  // With no winner the value comes from the start action's entry.
  assign val_sel = found_q ? best_q : start_val_q;

  // Update arithmetic.
  logic [RATE_W-1:0]  a_eff, g_eff, one_minus_a;
  logic signed [31:0] reward;
  logic signed [49:0] prod_g_d, prod_g_q, prod_g_rnd;
  logic signed [34:0] t_d, t_q;
  logic signed [49:0] prod_q_d, prod_q_q;
  logic signed [52:0] prod_t_d, prod_t_q;
  logic signed [53:0] sum_d, sum_rnd;
  logic signed [37:0] new_rnd;
  logic signed [31:0] q_cur_q, new_val_q;

  assign a_eff       = (lr_q > RATE_W'(Q_ONE)) ? RATE_W'(Q_ONE) : lr_q;
  assign g_eff       = (disc_q > RATE_W'(Q_ONE)) ? RATE_W'(Q_ONE) : disc_q;
  assign one_minus_a = RATE_W'(Q_ONE) - a_eff;

  always_comb begin
    unique case (item_q.reward_kind)
      RWD_FINISH:   reward = r_finish_q;
      RWD_ADJACENT: reward = r_adj_q;
      default:      reward = r_fail_q;
    endcase
  end

  // Rounding is half up: add one half, then floor by the shift.
  assign prod_g_d   = $signed({1'b0, g_eff}) * val_sel;
  assign prod_g_rnd = prod_g_q + 50'sd32768;
  assign t_d        = $signed({prod_g_rnd[49], prod_g_rnd[49:16]})
                      + $signed({{3{reward[31]}}, reward});
  assign prod_q_d   = $signed({1'b0, one_minus_a}) * q_cur_q;
  assign prod_t_d   = $signed({1'b0, a_eff}) * t_q;
  assign sum_d      = $signed({{4{prod_q_q[49]}}, prod_q_q})
                      + $signed({prod_t_q[52], prod_t_q});
  assign sum_rnd    = sum_d + 54'sd32768;
  assign new_rnd    = sum_rnd[53:16];

  // Saturate to the signed 32-bit range.
  always_comb begin
    if ((new_rnd[37:31] == 7'h00) || (new_rnd[37:31] == 7'h7F)) begin
      sat_d = new_rnd[31:0];
    end else if (new_rnd[37]) begin
      sat_d = 32'sh8000_0000;
    end else begin
      sat_d = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_q) begin
      q_cur_q <= rdata;
    end
    if (cmd_i.mul_g) begin
      prod_g_q <= prod_g_d;
    end
    if (cmd_i.tgt) begin
      t_q      <= t_d;
      prod_q_q <= prod_q_d;
    end
    if (cmd_i.mul_t) begin
      prod_t_q <= prod_t_d;
    end
    if (cmd_i.fin) begin
      new_val_q <= sat_d;
    end
  end

  // Output register: holds a result until the sink takes it.
  logic               out_valid_q;
  logic [2:0]         out_act_q;
  logic signed [31:0] out_best_q, out_new_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_act_q  <= best_act_q;
      out_best_q <= val_sel;
      out_new_q  <= (item_q.func == FUNC_QUERY) ? 32'sd0 : new_val_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_new_q, out_best_q, out_act_q};

  assign sts_o.clr_last  = (clr_cnt_q == LastAddr);
  assign sts_o.scan_last = (scan_idx_q == LastAct);
  assign sts_o.is_query  = (item_q.func == FUNC_QUERY);
  assign sts_o.out_free  = ~out_valid_q | m_axis_tready_i;

endmodule

FILE: rtl/tqle_controller.sv
module tqle_controller
  import tqle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid_i,
  input  tqle_sts_t sts_i,
  output logic      s_axis_tready_o,
  output tqle_cmd_t cmd_o
);

  typedef enum logic [12:0] {
    ST_CLEAR = 13'b0_0000_0000_0001,
    ST_IDLE  = 13'b0_0000_0000_0010,
    ST_ADDR1 = 13'b0_0000_0000_0100,
    ST_ADDR2 = 13'b0_0000_0000_1000,
    ST_SCAN  = 13'b0_0000_0001_0000,
    ST_DRAIN = 13'b0_0000_0010_0000,
    ST_RDCUR = 13'b0_0000_0100_0000,
    ST_CAPQ  = 13'b0_0000_1000_0000,
    ST_MULG  = 13'b0_0001_0000_0000,
    ST_TGT   = 13'b0_0010_0000_0000,
    ST_MULT  = 13'b0_0100_0000_0000,
    ST_FIN   = 13'b0_1000_0000_0000,
    ST_OUT   = 13'b1_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands for each step of a request.
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ADDR1;
        end
      end
      ST_ADDR1: begin
        cmd_o.addr1 = 1'b1;
        state_d     = ST_ADDR2;
      end
      ST_ADDR2: begin
        cmd_o.addr2 = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = sts_i.is_query ? ST_DRAIN : ST_RDCUR;
        end
      end
      ST_DRAIN: begin
        state_d = ST_OUT;
      end
      ST_RDCUR: begin
        cmd_o.cur_rd = 1'b1;
        state_d      = ST_CAPQ;
      end
      ST_CAPQ: begin
        cmd_o.cap_q = 1'b1;
        state_d     = ST_MULG;
      end
      ST_MULG: begin
        cmd_o.mul_g = 1'b1;
        state_d     = ST_TGT;
      end
      ST_TGT: begin
        cmd_o.tgt = 1'b1;
        state_d   = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mul_t = 1'b1;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: rtl/tqle_checker.sv
`include "assert_macros.svh"

module tqle_checker
  import tqle_pkg::*;
#(
  parameter int unsigned ACTIONS = ACTIONS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_i,
  input logic                   m_axis_tvalid_i,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_i
);

  logic in_acc, out_acc;
  logic out_stall, act_legal;
  logic [1:0] open_q;

  assign in_acc    = s_axis_tvalid_i & s_axis_tready_i;
  assign out_acc   = m_axis_tvalid_i & m_axis_tready_i;
  assign out_stall = m_axis_tvalid_i & ~m_axis_tready_i;
  assign act_legal = (32'(m_axis_tdata_i[2:0]) < ACTIONS)
                     || (m_axis_tdata_i[2:0] == START_ACTION);

  // Requests accepted whose results are not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 2'd0;
    end else begin
      open_q <= open_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  // A stalled result keeps its valid and its payload.
  `TQLE_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))

  // One request is worked on at a time.
  `TQLE_ASSERT(a_one_at_a_time, clk_i, rst_ni, in_acc |=> !s_axis_tready_i)

  // Every result belongs to an accepted request.
  `TQLE_ASSERT_NEVER(a_no_extra_result, clk_i, rst_ni, out_acc && open_q == 2'd0)

  // With one result waiting and one in work, no further request is taken.
  `TQLE_ASSERT(a_bounded_backlog, clk_i, rst_ni, open_q == 2'd2 |-> !s_axis_tready_i)

  // The greedy action is a table action or the start action.
  `TQLE_ASSERT(a_action_legal, clk_i, rst_ni, m_axis_tvalid_i |-> act_legal)

endmodule

bind tabular_q_learning_engine tqle_checker #(
  .ACTIONS (ACTIONS)
) u_tqle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

FILE: tb/tabular_q_learning_engine_checker.sv
// Watches the configuration port and both stream channels of the Q-learning
// engine. It keeps its own copy of both agent tables and registers, predicts
// the response of every accepted request and compares it with the engine.
module tabular_q_learning_engine_checker
  import tqle_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [IN_TUSER_W-1:0]  s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  output int                     fail_cnt_o,
  output int                     pending_o,
  output int                     checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH =
    GRID_SIDE_DEF * GRID_SIDE_DEF * DIRECTIONS_DEF * GRID_SIDE_DEF * ACTIONS_DEF;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [2:0]  best_action;
    logic [31:0] best_value;
    logic [31:0] new_value;
  } q_response_t;

  // Model state: one Q table per agent plus the register copies.
  int                q_tab [2][TABLE_DEPTH];
  logic [RATE_W-1:0] alpha_reg;
  logic [RATE_W-1:0] gamma_reg;
  logic signed [31:0] r_finish;
  logic signed [31:0] r_adjacent;
  logic signed [31:0] r_fail;

  q_response_t q_responses [$];
  q_response_t want;
  q_response_t got;
  int          mismatches;
  int          compared;

  function automatic int unsigned clamp_index(int unsigned v, int unsigned n);
    return (v >= n) ? n - 1 : v;
  endfunction

  // Address of action 0 of a state; every index saturates to its last entry.
  function automatic int unsigned entry_base(logic [2:0] x, logic [2:0] y,
                                             logic [3:0] d, logic [2:0] b);
    int unsigned idx;
    idx = clamp_index(x, GRID_SIDE_DEF);
    idx = idx * GRID_SIDE_DEF + clamp_index(y, GRID_SIDE_DEF);
    idx = idx * DIRECTIONS_DEF + clamp_index(d, DIRECTIONS_DEF);
    idx = idx * GRID_SIDE_DEF + clamp_index(b, GRID_SIDE_DEF);
    return idx * ACTIONS_DEF;
  endfunction

  // Round half up after dropping 16 fraction bits.
  function automatic longint q16_round(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  // Greedy action of a state: strict greater-than against the start value.
  function automatic void greedy_scan(logic ag, int unsigned base,
                                      output logic [2:0] act,
                                      output logic signed [31:0] val);
    longint     best;
    logic [2:0] pick;
    best = longint'(START_VALUE);
    pick = START_ACTION;
    for (int i = 0; i < ACTIONS_DEF; i++) begin
      if (longint'(q_tab[ag][base + i]) > best) begin
        best = longint'(q_tab[ag][base + i]);
        pick = i[2:0];
      end
    end
    act = pick;
    val = q_tab[ag][base + clamp_index(pick, ACTIONS_DEF)];
  endfunction

  // Computes the response of one request and applies an update to the table.
  function automatic q_response_t apply_request(logic [IN_TUSER_W-1:0] user,
                                                logic [IN_TDATA_W-1:0] data);
    logic               ag;
    int unsigned        cur;
    logic [2:0]         act;
    logic signed [31:0] val;
    longint             a;
    longint             g;
    longint             r;
    longint             t;
    longint             q;
    longint             s;
    longint             nv;
    q_response_t        res;
    ag = user[1];
    nv = 0;
    if (func_e'(user[0]) == FUNC_QUERY) begin
      greedy_scan(ag, entry_base(data[2:0], data[5:3], data[9:6], data[12:10]), act, val);
    end else begin
      cur = entry_base(data[2:0], data[5:3], data[9:6], data[12:10])
            + clamp_index(data[15:13], ACTIONS_DEF);
      greedy_scan(ag, entry_base(data[18:16], data[21:19], data[25:22], data[28:26]),
                  act, val);
      a = (alpha_reg > Q_ONE) ? longint'(Q_ONE) : longint'(alpha_reg);
      g = (gamma_reg > Q_ONE) ? longint'(Q_ONE) : longint'(gamma_reg);
      case (data[30:29])
        RWD_FINISH:   r = longint'(r_finish);
        RWD_ADJACENT: r = longint'(r_adjacent);
        default:      r = longint'(r_fail);
      endcase
      t  = r + q16_round(g * longint'(val));
      q  = longint'(q_tab[ag][cur]);
      s  = (longint'(Q_ONE) - a) * q + a * t;
      nv = q16_round(s);
      if (nv > 64'sd2147483647) nv = 64'sd2147483647;
      if (nv < -64'sd2147483648) nv = -64'sd2147483648;
      q_tab[ag][cur] = int'(nv);
    end
    res.best_action = act;
    res.best_value  = val;
    res.new_value   = nv[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got_v, longint want_v);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch at %0t: %s is %0d, predicted %0d", $time, what, got_v, want_v);
    end
    mismatches++;
  endtask

  // Track register writes, predict on each request, compare on each response.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ag = 0; ag < 2; ag++) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          q_tab[ag][i] = 0;
        end
      end
      alpha_reg  = LR_RESET;
      gamma_reg  = DISC_RESET;
      r_finish   = R_FINISH_RESET;
      r_adjacent = R_ADJ_RESET;
      r_fail     = R_FAIL_RESET;
      q_responses.delete();
      mismatches = 0;
      compared   = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
      checked_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_LEARNING_RATE:   alpha_reg  = cfg_wdata_i[RATE_W-1:0];
          CFG_DISCOUNT:        gamma_reg  = cfg_wdata_i[RATE_W-1:0];
          CFG_REWARD_FINISH:   r_finish   = cfg_wdata_i;
          CFG_REWARD_ADJACENT: r_adjacent = cfg_wdata_i;
          CFG_REWARD_FAIL:     r_fail     = cfg_wdata_i;
          default: ;
        endcase
      end

      if (s_tvalid_i && s_tready_i) begin
        q_responses.insert(q_responses.size(), apply_request(s_tuser_i, s_tdata_i));
      end

      if (m_tvalid_i && m_tready_i) begin
        got.best_action = m_tdata_i[2:0];
        got.best_value  = m_tdata_i[34:3];
        got.new_value   = m_tdata_i[66:35];
        if (q_responses.size() == 0) begin
          report_mismatch("response without a pending request, best_action",
                          got.best_action, 0);
        end else begin
          want = q_responses.pop_front();
          if (got.best_action != want.best_action) begin
            report_mismatch("best_action", got.best_action, want.best_action);
          end
          if (got.best_value != want.best_value) begin
            report_mismatch("best_value", $signed(got.best_value), $signed(want.best_value));
          end
          if (got.new_value != want.new_value) begin
            report_mismatch("new_value", $signed(got.new_value), $signed(want.new_value));
          end
          compared++;
        end
      end

      fail_cnt_o <= mismatches;
      pending_o  <= q_responses.size();
      checked_o  <= compared;
    end
  end

endmodule

FILE: tb/tabular_q_learning_engine_tb.sv
module tabular_q_learning_engine_tb;
  import tqle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PHASES        = 5;
  localparam int ITEMS_PER_PHASE = 260;
  localparam int RANDOM_ITEMS    = N_PHASES * ITEMS_PER_PHASE;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 20;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int POOL_SIZE       = 8;

  typedef enum int {
    IDLE_SENDER_LIGHT,
    IDLE_SENDER_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef struct packed {
    logic [2:0] x;
    logic [2:0] y;
    logic [3:0] dir;
    logic [2:0] blind;
  } grid_state_t;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [IN_TUSER_W-1:0]  s_tuser   = '0;
  logic                   m_tready  = 1'b0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int fail_cnt;
  int pending;
  int checked;

  // Back-pressure controls and their state, set by the stimulus process and the response side.
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  logic hold_req     = 1'b0;
  logic hold_done    = 1'b0;
  int   hold_left    = 0;
  int   cycle_cnt    = 0;

  int          n_updates = 0;
  int          n_queries = 0;
  grid_state_t state_pool [POOL_SIZE];
  logic [31:0] phase_cfg [N_PHASES][5];

  always #5 clk_i = ~clk_i;

  tabular_q_learning_engine u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  tabular_q_learning_engine_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Response side: random stalls, plus one long hold-off to fill the engine.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  function automatic tqle_item_t make_item(func_e f, logic ag, grid_state_t c,
                                           logic [2:0] act, grid_state_t n,
                                           logic [1:0] kind);
    tqle_item_t it;
    it.func        = f;
    it.agent       = ag;
    it.cur_x       = c.x;
    it.cur_y       = c.y;
    it.cur_dir     = c.dir;
    it.cur_blind   = c.blind;
    it.action      = act;
    it.next_x      = n.x;
    it.next_y      = n.y;
    it.next_dir    = n.dir;
    it.next_blind  = n.blind;
    it.reward_kind = kind;
    return it;
  endfunction

  // Mostly requests on a small pool of states so that entries build up and
  // interact; the rest is fully random over every field bit.
  function automatic tqle_item_t random_item();
    logic [63:0] raw;
    tqle_item_t  it;
    if ($urandom_range(99) < 80) begin
      it = make_item(func_e'(($urandom_range(99) < 30) ? FUNC_QUERY : FUNC_UPDATE),
                     1'($urandom_range(1)), state_pool[$urandom_range(POOL_SIZE-1)],
                     3'($urandom_range(7)), state_pool[$urandom_range(POOL_SIZE-1)],
                     2'($urandom_range(3)));
    end else begin
      raw = {$urandom, $urandom};
      it  = raw[$bits(tqle_item_t)-1:0];
    end
    return it;
  endfunction

  task automatic set_idle_mode(idle_mode_e mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        snd_idle_pct = 15;
        rcv_idle_pct <= 74;
      end
      IDLE_SENDER_HEAVY: begin
        snd_idle_pct = 74;
        rcv_idle_pct <= 15;
      end
      default: begin
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
      end
    endcase
  endtask

  // Offers one request, with random idle cycles ahead of it.
  task automatic send_request(tqle_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {it.agent, it.func};
    s_tdata  <= {1'b0, it.reward_kind, it.next_blind, it.next_dir, it.next_y, it.next_x,
                 it.action, it.cur_blind, it.cur_dir, it.cur_y, it.cur_x};
    do @(posedge clk_i); while (!s_tready);
    if (it.func == FUNC_QUERY) n_queries++;
    else n_updates++;
  endtask

  // Waits until every request has its response, then lets the engine settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] lr, logic [31:0] disc, logic [31:0] fin,
                           logic [31:0] adj, logic [31:0] fail_r);
    write_reg(CFG_LEARNING_RATE, lr);
    write_reg(CFG_DISCOUNT, disc);
    write_reg(CFG_REWARD_FINISH, fin);
    write_reg(CFG_REWARD_ADJACENT, adj);
    write_reg(CFG_REWARD_FAIL, fail_r);
    cfg_we <= 1'b0;
  endtask

  initial begin
    grid_state_t s_zero;
    grid_state_t s_max;
    grid_state_t s_one;
    grid_state_t s_neg;
    grid_state_t s_sat;
    int          k;

    s_zero = '0;
    s_max  = {3'd7, 3'd7, 4'd15, 3'd7};
    s_one  = {3'd1, 3'd1, 4'd1, 3'd1};
    s_neg  = {3'd2, 3'd5, 4'd3, 3'd6};
    s_sat  = {3'd6, 3'd2, 4'd8, 3'd0};
    for (int i = 0; i < POOL_SIZE; i++) begin
      state_pool[i].x     = 3'($urandom_range(7));
      state_pool[i].y     = 3'($urandom_range(7));
      state_pool[i].dir   = 4'($urandom_range(9));
      state_pool[i].blind = 3'($urandom_range(7));
    end

    // Register settings of the random phases: extremes, zero rates, rates
    // above one, random rates, then the reset values again.
    phase_cfg[0] = '{Q_ONE, Q_ONE, 32'h7FFF_FFFF, 32'h8000_0000, $urandom};
    phase_cfg[1] = '{32'd0, 32'd0, $urandom, $urandom, $urandom};
    phase_cfg[2] = '{32'h1_FFFF, 32'h1_FFFF, $urandom_range(2**21) - 2**20,
                     $urandom_range(2**21) - 2**20, $urandom_range(2**21) - 2**20};
    phase_cfg[3] = '{$urandom_range(Q_ONE), $urandom_range(Q_ONE),
                     $urandom_range(2**25) - 2**24, $urandom_range(2**25) - 2**24,
                     $urandom_range(2**25) - 2**24};
    phase_cfg[4] = '{LR_RESET, DISC_RESET, R_FINISH_RESET, R_ADJ_RESET, R_FAIL_RESET};

    set_idle_mode(IDLE_SENDER_LIGHT);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at reset values: empty tables, saturated indexes,
    // the same entry read and written, and the unknown reward kind.
    send_request(make_item(FUNC_QUERY, 1'b0, s_zero, 3'd0, s_zero, RWD_FAIL));
    send_request(make_item(FUNC_QUERY, 1'b1, s_max, 3'd0, s_max, RWD_FAIL));
    send_request(make_item(FUNC_UPDATE, 1'b0, s_max, 3'd7, s_zero, RWD_FINISH));
    send_request(make_item(FUNC_UPDATE, 1'b0, s_one, 3'd0, s_one, RWD_ADJACENT));
    send_request(make_item(FUNC_UPDATE, 1'b1, s_one, 3'd2, s_max, 2'd3));
    send_request(make_item(FUNC_QUERY, 1'b0, s_max, 3'd0, s_zero, RWD_FAIL));
    wait_drained();

    // Directed requests at full rates and extreme rewards: a state where no
    // action beats the start value, and saturation at both ends.
    write_all(Q_ONE, Q_ONE, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    for (int a = 0; a < ACTIONS_DEF; a++) begin
      send_request(make_item(FUNC_UPDATE, 1'b0, s_neg, 3'(a), s_zero, RWD_FAIL));
    end
    send_request(make_item(FUNC_QUERY, 1'b0, s_neg, 3'd0, s_zero, RWD_FAIL));
    send_request(make_item(FUNC_UPDATE, 1'b0, s_sat, 3'd0, s_neg, RWD_FAIL));
    send_request(make_item(FUNC_UPDATE, 1'b1, s_sat, 3'd0, s_zero, RWD_FINISH));
    send_request(make_item(FUNC_UPDATE, 1'b1, s_sat, 3'd1, s_sat, RWD_FINISH));
    send_request(make_item(FUNC_QUERY, 1'b1, s_sat, 3'd0, s_zero, RWD_FAIL));
    send_request(make_item(FUNC_UPDATE, 1'b0, s_neg, 3'd4, s_neg, RWD_ADJACENT));
    wait_drained();

    // Random phases, one register setting each.
    k = 0;
    for (int p = 0; p < N_PHASES; p++) begin
      write_all(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3],
                phase_cfg[p][4]);
      if (p == 2) hold_req <= 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (k < RANDOM_ITEMS / 3) set_idle_mode(IDLE_SENDER_LIGHT);
        else if (k < 2 * RANDOM_ITEMS / 3) set_idle_mode(IDLE_SENDER_HEAVY);
        else set_idle_mode(IDLE_NONE);
        send_request(random_item());
        k++;
      end
      wait_drained();
    end

    $display("summary: %0d updates and %0d queries over %0d register settings,",
             n_updates, n_queries, N_PHASES + 2);
    $display("summary: %0d responses compared, one %0d-cycle response hold-off",
             checked, HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
